// ===== hdl/ps2_mouse_packet_cursor_tracker_assert.svh =====
// Assertion macros used by the cursor tracker checker
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

// Check cons in the cycle after ante holds
`define PMPCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor tracker check failed");

// Check cons in the same cycle as ante
`define PMPCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor tracker check failed");

`endif

// ===== hdl/pmpct_pkg.sv =====
// Types, constants and codes for the PS/2 mouse cursor tracker
package pmpct_pkg;

    localparam int COORD_BITS_DEF  = 13;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int OUT_COORD_W     = 13;
    localparam int SIZE_W          = 14;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 14;
    localparam int RESET_SCREEN_W  = 1024;
    localparam int RESET_SCREEN_H  = 768;

    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_RECENTRE = 1'b1;

    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;
    localparam logic [7:0] HDR_OVF_MASK = 8'hC0;
    localparam int BTN_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WHEEL_MODE = 2'd0,
        REG_SCREEN_W   = 2'd1,
        REG_SCREEN_H   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic                   moved;
        logic                   clicked;
        logic [OUT_COORD_W-1:0] cursor_x;
        logic [OUT_COORD_W-1:0] cursor_y;
        logic [BTN_W-1:0]       button_bits;
        logic                   pressed;
        logic signed [7:0]      wheel;
    } out_item_t;

    typedef enum logic {
        CMD_PACKET   = 1'b0,
        CMD_RECENTRE = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [BTN_W-1:0]  buttons;
        logic              overflow;
        logic signed [8:0] dx;
        logic signed [9:0] dyz;
        logic signed [7:0] wheel;
    } cmd_t;

endpackage

// ===== hdl/pmpct_front.sv =====
// Packet assembler: classifies mouse bytes and issues cursor commands
module pmpct_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  pmpct_pkg::in_item_t in_data,
    input  logic               wheel_mode,
    output logic               push,
    output pmpct_pkg::cmd_t    push_cmd
);
    import pmpct_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DX    = 2'd1,
        PH_DY    = 2'd2,
        PH_WHEEL = 2'd3
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        header_reg, header_next;
    logic [7:0]        dx_reg, dx_next;
    logic [7:0]        dy_reg, dy_next;
    logic              hdr;
    logic              recentre;
    logic [7:0]        pkt_dy;
    logic signed [7:0] pkt_wheel;
    logic signed [8:0] dy_ext;

    assign hdr = in_data.rx_byte[HDR_SYNC_BIT];

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        push        = 1'b0;
        recentre    = 1'b0;
        pkt_dy      = dy_reg;
        pkt_wheel   = '0;
        if (accept)
        begin
            if (in_data.op == OP_RECENTRE)
            begin
                phase_next = PH_IDLE;
                push       = 1'b1;
                recentre   = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (hdr)
                        begin
                            header_next = in_data.rx_byte;
                            phase_next  = PH_DX;
                        end
                    end
                    PH_DX:
                    begin
                        if (hdr)
                        begin
                            header_next = in_data.rx_byte;
                        end
                        else
                        begin
                            dx_next    = in_data.rx_byte;
                            phase_next = PH_DY;
                        end
                    end
                    PH_DY:
                    begin
                        if (hdr)
                        begin
                            header_next = in_data.rx_byte;
                            phase_next  = PH_DX;
                        end
                        else
                        begin
                            dy_next = in_data.rx_byte;
                            pkt_dy  = in_data.rx_byte;
                            if (wheel_mode)
                            begin
                                phase_next = PH_WHEEL;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                push       = 1'b1;
                            end
                        end
                    end
                    PH_WHEEL:
                    begin
                        push = 1'b1;
                        if (hdr)
                        begin
                            header_next = in_data.rx_byte;
                            phase_next  = PH_DX;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            if (wheel_mode)
                            begin
                                pkt_wheel = $signed(in_data.rx_byte);
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign dy_ext = $signed({header_reg[HDR_YSIGN_BIT], pkt_dy});

    always_comb
    begin
        push_cmd.kind     = recentre ? CMD_RECENTRE : CMD_PACKET;
        push_cmd.buttons  = header_reg[BTN_W-1:0];
        push_cmd.overflow = |(header_reg & HDR_OVF_MASK);
        push_cmd.dx       = $signed({header_reg[HDR_XSIGN_BIT], dx_reg});
        push_cmd.dyz      = 10'(dy_ext) + 10'(pkt_wheel);
        push_cmd.wheel    = pkt_wheel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            header_reg <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
        end
    end

endmodule

// ===== hdl/pmpct_queue.sv =====
// Short command queue between the packet assembler and the cursor stage
module pmpct_queue #(
    parameter int DEPTH = pmpct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pmpct_pkg::cmd_t push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output pmpct_pkg::cmd_t head
);
    import pmpct_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/pmpct_back.sv =====
// Cursor stage: applies commands to the cursor and registers results
module pmpct_back #(
    parameter int COORD_BITS = pmpct_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  pmpct_pkg::cmd_t              q_head,
    output logic                         q_pop,
    input  logic [pmpct_pkg::SIZE_W-1:0] screen_w,
    input  logic [pmpct_pkg::SIZE_W-1:0] screen_h,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pmpct_pkg::out_item_t         out_data
);
    import pmpct_pkg::*;

    localparam int LW = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
    localparam int SW = LW + 3;
    localparam logic [LW-1:0] CAP = LW'(1) << COORD_BITS;
    localparam int RST_LIM_W = (RESET_SCREEN_W > (1 << COORD_BITS)) ?
                               (1 << COORD_BITS) : RESET_SCREEN_W;
    localparam int RST_LIM_H = (RESET_SCREEN_H > (1 << COORD_BITS)) ?
                               (1 << COORD_BITS) : RESET_SCREEN_H;
    localparam logic [COORD_BITS-1:0] RST_X = COORD_BITS'(RST_LIM_W / 2);
    localparam logic [COORD_BITS-1:0] RST_Y = COORD_BITS'(RST_LIM_H / 2);

    function automatic logic [LW-1:0] eff_limit(input logic [SIZE_W-1:0] size);
        logic [LW-1:0] ext;
        ext = LW'(size);
        if (size == '0)
            return LW'(1);
        if (ext > CAP)
            return CAP;
        return ext;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [SW-1:0] v,
                                                          input logic [LW-1:0] lim);
        logic signed [SW-1:0] lim_s;
        lim_s = $signed(SW'(lim));
        if (v < 0)
            return '0;
        if (v >= lim_s)
            return COORD_BITS'(lim - LW'(1));
        return COORD_BITS'(v);
    endfunction

    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic [BTN_W-1:0]      last_buttons_reg, last_buttons_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg, out_data_next;
    logic [LW-1:0]         lim_x, lim_y;
    logic signed [SW-1:0]  nx, ny;
    logic [BTN_W-1:0]      changed;

    assign lim_x   = eff_limit(screen_w);
    assign lim_y   = eff_limit(screen_h);
    assign nx      = $signed(SW'(pos_x_reg)) + SW'(q_head.dx);
    assign ny      = $signed(SW'(pos_y_reg)) - SW'(q_head.dyz);
    assign changed = q_head.buttons ^ last_buttons_reg;
    assign q_pop   = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        last_buttons_next = last_buttons_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        if (q_pop)
        begin
            case (q_head.kind)
                CMD_RECENTRE:
                begin
                    pos_x_next = COORD_BITS'(lim_x >> 1);
                    pos_y_next = COORD_BITS'(lim_y >> 1);
                end
                CMD_PACKET:
                begin
                    last_buttons_next = q_head.buttons;
                    if (!q_head.overflow)
                    begin
                        pos_x_next = clamp_coord(nx, lim_x);
                        pos_y_next = clamp_coord(ny, lim_y);
                    end
                    out_valid_next            = 1'b1;
                    out_data_next.moved       = !q_head.overflow;
                    out_data_next.clicked     = |changed;
                    out_data_next.cursor_x    = OUT_COORD_W'(pos_x_next);
                    out_data_next.cursor_y    = OUT_COORD_W'(pos_y_next);
                    out_data_next.button_bits = q_head.buttons;
                    out_data_next.pressed     = |(q_head.buttons & changed);
                    out_data_next.wheel       = q_head.wheel;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !out_ready;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg        <= RST_X;
            pos_y_reg        <= RST_Y;
            last_buttons_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            last_buttons_reg <= last_buttons_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/ps2_mouse_packet_cursor_tracker.sv =====
// PS/2 mouse packet decoder with cursor tracking, top level
// Takes one byte or recentre request per cycle while the command queue has room:
// the packet assembler classifies each byte in its cycle of transfer and the cursor
// stage finishes one command per cycle, while no result waits for its transfer,
// with a single add and clamp. The command of a completed packet passes the
// command queue and then the output register; the queue lets the assembler
// keep taking bytes while a result waits for its transfer.
module ps2_mouse_packet_cursor_tracker #(
    parameter int COORD_BITS  = pmpct_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = pmpct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pmpct_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pmpct_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pmpct_pkg::in_item_t               in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pmpct_pkg::out_item_t              out_data
);
    import pmpct_pkg::*;

    logic              wheel_mode_reg;
    logic [SIZE_W-1:0] screen_w_reg;
    logic [SIZE_W-1:0] screen_h_reg;
    logic              accept;
    logic              push;
    cmd_t              push_cmd;
    logic              q_full;
    logic              q_valid;
    cmd_t              q_head;
    logic              q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mode_reg <= 1'b0;
            screen_w_reg   <= SIZE_W'(RESET_SCREEN_W);
            screen_h_reg   <= SIZE_W'(RESET_SCREEN_H);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WHEEL_MODE: wheel_mode_reg <= cfg_data[0];
                REG_SCREEN_W:   screen_w_reg   <= SIZE_W'(cfg_data);
                REG_SCREEN_H:   screen_h_reg   <= SIZE_W'(cfg_data);
                default:        wheel_mode_reg <= wheel_mode_reg;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    pmpct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_data    (in_data),
        .wheel_mode (wheel_mode_reg),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    pmpct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    pmpct_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .screen_w  (screen_w_reg),
        .screen_h  (screen_h_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/pmpct_checker.sv =====
// Port checker for the cursor tracker and its bind to the top level
`include "ps2_mouse_packet_cursor_tracker_assert.svh"

module pmpct_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input pmpct_pkg::out_item_t out_data
);
    import pmpct_pkg::*;

    // hold a result until its transfer
    `PMPCT_ASSERT_NEXT(out_hold_a, clk, rst_n, out_valid && !out_ready, out_valid)
    `PMPCT_ASSERT_NEXT(out_stable_a, clk, rst_n, out_valid && !out_ready, $stable(out_data))
    `PMPCT_ASSERT_NOW(pressed_click_a, clk, rst_n, out_valid && out_data.pressed, out_data.clicked)
    // queue is empty straight after reset
    `PMPCT_ASSERT_NOW(ready_after_reset_a, clk, rst_n, $rose(rst_n), in_ready || !in_valid)

endmodule

bind ps2_mouse_packet_cursor_tracker pmpct_checker u_checker (.*);

// ===== tb/tb_ps2_mouse_packet_cursor_tracker.sv =====
// Self-checking testbench for the PS/2 mouse packet cursor tracker
import pmpct_pkg::*;

class cursor_ledger;
    typedef enum logic [1:0] {WAIT_HEADER, WAIT_DX, WAIT_DY, WAIT_WHEEL} asm_phase_t;

    bit         wheel_on;
    bit [13:0]  width_reg;
    bit [13:0]  height_reg;
    asm_phase_t phase;
    bit [7:0]   hdr;
    bit [7:0]   dx_b;
    bit [7:0]   dy_b;
    bit [12:0]  px;
    bit [12:0]  py;
    bit [2:0]   last_btn;
    out_item_t  pending_reports[$];
    int         errors;

    function new();
        wheel_on   = 1'b0;
        width_reg  = RESET_SCREEN_W;
        height_reg = RESET_SCREEN_H;
        phase      = WAIT_HEADER;
        hdr        = '0;
        dx_b       = '0;
        dy_b       = '0;
        last_btn   = '0;
        errors     = 0;
        recentre();
    endfunction

    function int span(bit [13:0] size);
        if (size == 0)
            return 1;
        if (size > (1 << COORD_BITS_DEF))
            return 1 << COORD_BITS_DEF;
        return size;
    endfunction

    function int clamp(int v, int lim);
        if (v < 0)
            return 0;
        if (v >= lim)
            return lim - 1;
        return v;
    endfunction

    function void recentre();
        px = span(width_reg) / 2;
        py = span(height_reg) / 2;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [13:0] val);
        case (idx)
            REG_WHEEL_MODE: wheel_on = val[0];
            REG_SCREEN_W:   width_reg = val;
            REG_SCREEN_H:   height_reg = val;
            default: ;
        endcase
    endfunction

    function void close_packet(int dz);
        out_item_t r;
        bit [2:0]  newb;
        bit [2:0]  changed;
        int        dx;
        int        dy;
        newb     = hdr[2:0];
        changed  = newb ^ last_btn;
        last_btn = newb;
        r.moved  = 1'b0;
        if ((hdr & HDR_OVF_MASK) == 8'h00)
        begin
            dx = int'(dx_b) - (hdr[HDR_XSIGN_BIT] ? 256 : 0);
            dy = int'(dy_b) - (hdr[HDR_YSIGN_BIT] ? 256 : 0);
            px = clamp(int'(px) + dx, span(width_reg));
            py = clamp(int'(py) - dy - dz, span(height_reg));
            r.moved = 1'b1;
        end
        r.clicked     = |changed;
        r.cursor_x    = px;
        r.cursor_y    = py;
        r.button_bits = newb;
        r.pressed     = |(newb & changed);
        r.wheel       = dz[7:0];
        pending_reports.push_back(r);
    endfunction

    function void note_input(in_item_t it);
        bit             is_hdr;
        bit [7:0]       b;
        bit signed [7:0] sb;
        b      = it.rx_byte;
        sb     = b;
        is_hdr = b[HDR_SYNC_BIT];
        if (it.op == OP_RECENTRE)
        begin
            recentre();
            phase = WAIT_HEADER;
            return;
        end
        case (phase)
            WAIT_HEADER:
                if (is_hdr)
                begin
                    hdr   = b;
                    phase = WAIT_DX;
                end
            WAIT_DX:
                if (is_hdr)
                    hdr = b;
                else
                begin
                    dx_b  = b;
                    phase = WAIT_DY;
                end
            WAIT_DY:
                if (is_hdr)
                begin
                    hdr   = b;
                    phase = WAIT_DX;
                end
                else
                begin
                    dy_b = b;
                    if (wheel_on)
                        phase = WAIT_WHEEL;
                    else
                    begin
                        phase = WAIT_HEADER;
                        close_packet(0);
                    end
                end
            default:
                if (is_hdr)
                begin
                    close_packet(0);
                    hdr   = b;
                    phase = WAIT_DX;
                end
                else
                begin
                    phase = WAIT_HEADER;
                    close_packet(wheel_on ? int'(sb) : 0);
                end
        endcase
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (pending_reports.size() == 0)
        begin
            $error("unexpected result %p", got);
            errors++;
            return;
        end
        want = pending_reports.pop_front();
        if (got.moved !== want.moved)
        begin
            $error("moved: expected %0d, got %0d", want.moved, got.moved);
            errors++;
        end
        if (got.clicked !== want.clicked)
        begin
            $error("clicked: expected %0d, got %0d", want.clicked, got.clicked);
            errors++;
        end
        if (got.cursor_x !== want.cursor_x)
        begin
            $error("cursor_x: expected %0d, got %0d", want.cursor_x, got.cursor_x);
            errors++;
        end
        if (got.cursor_y !== want.cursor_y)
        begin
            $error("cursor_y: expected %0d, got %0d", want.cursor_y, got.cursor_y);
            errors++;
        end
        if (got.button_bits !== want.button_bits)
        begin
            $error("button_bits: expected %0d, got %0d", want.button_bits, got.button_bits);
            errors++;
        end
        if (got.pressed !== want.pressed)
        begin
            $error("pressed: expected %0d, got %0d", want.pressed, got.pressed);
            errors++;
        end
        if (got.wheel !== want.wheel)
        begin
            $error("wheel: expected %0d, got %0d", want.wheel, got.wheel);
            errors++;
        end
    endfunction
endclass

module tb_ps2_mouse_packet_cursor_tracker;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;

    cursor_ledger ledger;
    bit           calm;
    int           cycle_count;
    int           received;

    ps2_mouse_packet_cursor_tracker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function int draw_gap();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function logic [7:0] random_header();
        logic [7:0] h;
        h = $urandom_range(0, 255);
        h[HDR_SYNC_BIT] = 1'b1;
        if ($urandom_range(0, 3) != 0)
            h = h & ~HDR_OVF_MASK;
        return h;
    endfunction

    function logic [7:0] random_data();
        logic [7:0] d;
        d = $urandom_range(0, 255);
        d[HDR_SYNC_BIT] = 1'b0;
        return d;
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        ledger.note_input(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        in_item_t it;
        it.op      = OP_BYTE;
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_recentre(logic [7:0] b);
        in_item_t it;
        it.op      = OP_RECENTRE;
        it.rx_byte = b;
        send_item(it);
    endtask

    // drain all results and let any recentre leave the pipeline
    task automatic settle();
        in_valid <= 1'b0;
        while (ledger.pending_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        ledger.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_burst();
        int kind;
        int len;
        kind = $urandom_range(0, 19);
        if (kind == 0)
            send_recentre($urandom_range(0, 255));
        else if (kind == 1)
            send_byte($urandom_range(0, 255));
        else if (kind == 2)
        begin
            len = $urandom_range(0, 2);
            send_byte(random_header());
            repeat (len) send_byte(random_data());
        end
        else
        begin
            send_byte(random_header());
            send_byte(random_data());
            send_byte(random_data());
            if (ledger.wheel_on && $urandom_range(0, 5) != 0)
                send_byte(random_data());
        end
    endtask

    initial
    begin
        int                    wheel_cfg;
        logic [CFG_DATA_W-1:0] w_cfg;
        logic [CFG_DATA_W-1:0] h_cfg;
        ledger    = new();
        calm      = 1'b0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_WHEEL_MODE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // three-byte packets at the reset configuration
        send_byte(8'h00);
        send_byte(8'h08);
        send_byte(8'hF7);
        send_byte(8'h77);
        send_byte(8'h3F);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hC8);
        send_byte(8'h50);
        send_byte(8'h60);
        send_byte(8'h09);
        send_byte(8'h0A);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h0C);
        send_byte(8'h03);
        send_byte(8'h1C);
        send_byte(8'hF0);
        send_byte(8'h04);
        send_recentre(8'hFF);
        settle();

        // wheel packets on an out-of-range screen
        write_reg(REG_WHEEL_MODE, 1);
        write_reg(REG_SCREEN_W, 0);
        write_reg(REG_SCREEN_H, 16383);
        send_recentre(8'h00);
        send_byte(8'h08);
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h80);
        send_byte(8'h09);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h0B);
        send_byte(8'h05);
        send_byte(8'h06);
        send_byte(8'h77);
        send_byte(8'h08);
        send_byte(8'h01);
        send_byte(8'h02);
        settle();

        // drop wheel mode while a wheel byte is awaited
        write_reg(REG_WHEEL_MODE, 0);
        send_byte(8'h45);
        settle();

        // shrink the screen under a centred cursor
        write_reg(REG_SCREEN_W, 8192);
        write_reg(REG_SCREEN_H, 8192);
        send_recentre(8'h00);
        settle();
        write_reg(REG_SCREEN_W, 10);
        write_reg(REG_SCREEN_H, 20);
        send_byte(8'hC8);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h08);
        send_byte(8'h00);
        send_byte(8'h00);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            wheel_cfg = p % 2;
            case (p)
                0:       begin w_cfg = 1024;  h_cfg = 768;   end
                1:       begin w_cfg = 8192;  h_cfg = 8192;  end
                2:       begin w_cfg = 1;     h_cfg = 1;     end
                3:       begin w_cfg = 16383; h_cfg = 0;     end
                5:       begin w_cfg = 2;     h_cfg = 3;     end
                7:       begin w_cfg = 640;   h_cfg = 480;   end
                default:
                begin
                    w_cfg = $urandom_range(1, 8192);
                    h_cfg = $urandom_range(1, 8192);
                end
            endcase
            write_reg(REG_WHEEL_MODE, wheel_cfg);
            write_reg(REG_SCREEN_W, w_cfg);
            write_reg(REG_SCREEN_H, h_cfg);
            if ($urandom_range(0, 1) != 0)
                send_recentre($urandom_range(0, 255));
            calm = (p % 3 == 2);
            repeat (16) random_burst();
            settle();
        end

        repeat (20) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, with two long holds to back up the block
    initial
    begin
        int stall;
        received  = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (received == 30 || received == 150)
                stall = LONG_HOLD;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            ledger.check_result(out_data);
            received++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end
endmodule
